// ===== rtl/slc_pkg.sv =====
// Shared widths, codes and types of the set-associative LRU cache tracker.
package slc_pkg;

    localparam int TAG_W        = 32;
    localparam int AGE_W        = 3;
    localparam int OPCODE_W     = 2;
    localparam int ADDRESS_W    = 32;
    localparam int HIT_CNT_W    = 2;
    localparam int TOTAL_W      = 32;

    localparam int SET_BITS_W   = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_CFG_W   = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 5;

    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST    = 4'd4;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST  = 5'd4;
    localparam logic [WAYS_CFG_W-1:0]   WAYS_IN_USE_RST = 4'd1;

    typedef struct packed {
        logic [HIT_CNT_W-1:0] hit_count;
        logic                 missed;
        logic                 evicted;
    } slc_result_t;

endpackage

// ===== rtl/slc_channels.sv =====
// Handshake channels for access words and result words.
interface slc_access_if;
    logic                          valid;
    logic                          ready;
    logic [slc_pkg::OPCODE_W-1:0]  opcode;
    logic [slc_pkg::ADDRESS_W-1:0] address;

    modport source (output valid, opcode, address, input ready);
    modport sink (input valid, opcode, address, output ready);
endinterface

interface slc_result_if;
    logic                          valid;
    logic                          ready;
    logic [slc_pkg::HIT_CNT_W-1:0] hit_count;
    logic                          missed;
    logic                          evicted;
    logic [slc_pkg::TOTAL_W-1:0]   total_hits;
    logic [slc_pkg::TOTAL_W-1:0]   total_misses;
    logic [slc_pkg::TOTAL_W-1:0]   total_evictions;

    modport source (output valid, hit_count, missed, evicted, total_hits, total_misses,
                    total_evictions, input ready);
    modport sink (input valid, hit_count, missed, evicted, total_hits, total_misses,
                  total_evictions, output ready);
endinterface

// ===== rtl/slc_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/slc_set_update.sv =====
// Lookup, fill and LRU age update of one set row of the tag store.
module slc_set_update #(
    parameter int MAX_WAYS = 8
) (
    input  logic [MAX_WAYS*(1+slc_pkg::AGE_W+slc_pkg::TAG_W)-1:0] row_in,
    input  logic [slc_pkg::TAG_W-1:0]                              tag,
    input  logic [$clog2(MAX_WAYS+1)-1:0]                          ways_eff,
    input  logic [slc_pkg::OPCODE_W-1:0]                           opcode,
    output logic [MAX_WAYS*(1+slc_pkg::AGE_W+slc_pkg::TAG_W)-1:0] row_out,
    output slc_pkg::slc_result_t                                   res
);

    localparam int LINE_W = 1 + slc_pkg::AGE_W + slc_pkg::TAG_W;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WC_W   = $clog2(MAX_WAYS + 1);

    typedef logic [MAX_WAYS-1:0][slc_pkg::AGE_W-1:0] age_vec_t;

    logic [MAX_WAYS-1:0]                    valid_in;
    logic [MAX_WAYS-1:0]                    valid_new;
    logic [MAX_WAYS-1:0][slc_pkg::TAG_W-1:0] tag_in;
    age_vec_t                               age_in;
    age_vec_t                               age_one;
    age_vec_t                               age_two;
    logic [MAX_WAYS-1:0]                    in_use;
    logic [MAX_WAYS-1:0]                    hit_vec;
    logic [MAX_WAYS-1:0]                    free_vec;
    logic                                   hit;
    logic                                   has_free;
    logic [WAY_W-1:0]                       hit_way;
    logic [WAY_W-1:0]                       free_way;
    logic [WAY_W-1:0]                       lru_way;
    logic [WAY_W-1:0]                       way_sel;
    logic [slc_pkg::AGE_W-1:0]              age_top;
    logic                                   active;
    logic                                   modify;

    function automatic age_vec_t touch(
        input age_vec_t                  ages,
        input logic [MAX_WAYS-1:0]       vld,
        input logic [MAX_WAYS-1:0]       used,
        input logic [WAY_W-1:0]          way,
        input logic [slc_pkg::AGE_W-1:0] top
    );
        age_vec_t                  r;
        logic [slc_pkg::AGE_W-1:0] old;
        begin
            r   = ages;
            old = ages[way];
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (used[w] && (WAY_W'(w) != way) && vld[w] && (ages[w] > old))
                begin
                    r[w] = ages[w] - 1'b1;
                end
            end
            r[way] = top;
            return r;
        end
    endfunction

    always_comb
    begin
        active  = (opcode != slc_pkg::OP_NONE);
        modify  = (opcode == slc_pkg::OP_MODIFY);
        age_top = slc_pkg::AGE_W'(ways_eff - WC_W'(1));

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            tag_in[w]   = row_in[w*LINE_W +: slc_pkg::TAG_W];
            age_in[w]   = row_in[w*LINE_W + slc_pkg::TAG_W +: slc_pkg::AGE_W];
            valid_in[w] = row_in[w*LINE_W + slc_pkg::TAG_W + slc_pkg::AGE_W];
            in_use[w]   = (w < int'(ways_eff));
            hit_vec[w]  = in_use[w] && valid_in[w] && (tag_in[w] == tag);
            free_vec[w] = in_use[w] && !valid_in[w];
        end

        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (free_vec[w])
            begin
                has_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end

        lru_way = '0;
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && (age_in[w] < age_in[lru_way]))
            begin
                lru_way = WAY_W'(w);
            end
        end

        if (hit)
        begin
            way_sel = hit_way;
        end
        else if (has_free)
        begin
            way_sel = free_way;
        end
        else
        begin
            way_sel = lru_way;
        end

        valid_new          = valid_in;
        valid_new[way_sel] = 1'b1;

        age_one = touch(age_in, valid_new, in_use, way_sel, age_top);
        age_two = modify ? touch(age_one, valid_new, in_use, way_sel, age_top) : age_one;

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            row_out[w*LINE_W +: slc_pkg::TAG_W] =
                (WAY_W'(w) == way_sel) ? tag : tag_in[w];
            row_out[w*LINE_W + slc_pkg::TAG_W +: slc_pkg::AGE_W] = age_two[w];
            row_out[w*LINE_W + slc_pkg::TAG_W + slc_pkg::AGE_W]  = valid_new[w];
        end

        res.hit_count = active ? (slc_pkg::HIT_CNT_W'(hit) + slc_pkg::HIT_CNT_W'(modify)) : '0;
        res.missed    = active && !hit;
        res.evicted   = active && !hit && !has_free;
    end

endmodule

// ===== rtl/set_assoc_lru_cache_tracker_core.sv =====
// Top level of the set-associative LRU cache tracker.
// Each access word carries an opcode (load, store, modify, or the unused code, which makes
// no lookup) and a byte address. Each access gives exactly one result word: hits of this
// access, miss and eviction flags, and the running totals after it.
// The configuration port writes set_bits, block_bits and ways_in_use by index; the user must
// make writes only while no access is in flight, as the block itself does not enforce it.
// An accepted access passes through the registered read of the set row and then the update
// into the result register. One access is accepted per cycle when the result side keeps
// up; the set row of the tag store RAM is read through the registered read port and
// written back when the access advances, and a forwarding register supplies the row when
// the next access falls in the set just written.
// After reset the block clears the tag store one set a cycle, all 2**MAX_SET_BITS sets
// (1024 with the default), with ready low; configuration writes are taken throughout.
// When the receiver stalls, the result word holds and one further access may be taken
// into the lookup stage, after which ready stays low until the result is taken.
module set_assoc_lru_cache_tracker_core #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS     = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [slc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]     cfg_data,
    slc_access_if.sink                         access,
    slc_result_if.source                       result
);

    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int LINE_W = 1 + slc_pkg::AGE_W + slc_pkg::TAG_W;
    localparam int ROW_W  = MAX_WAYS * LINE_W;
    localparam int WC_W   = $clog2(MAX_WAYS + 1);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [SET_AW-1:0]                 clr_cnt_reg;
    logic [SET_AW-1:0]                 clr_cnt_next;

    logic [slc_pkg::SET_BITS_W-1:0]    set_bits_reg;
    logic [slc_pkg::BLOCK_BITS_W-1:0]  block_bits_reg;
    logic [slc_pkg::WAYS_CFG_W-1:0]    ways_in_use_reg;

    logic                              busy_reg;
    logic [slc_pkg::OPCODE_W-1:0]      op_reg;
    logic [SET_AW-1:0]                 set_reg;
    logic [slc_pkg::TAG_W-1:0]         tag_reg;

    logic                              fwd_valid_reg;
    logic [SET_AW-1:0]                 fwd_set_reg;
    logic [ROW_W-1:0]                  fwd_row_reg;

    logic                              out_valid_reg;
    slc_pkg::slc_result_t              res_reg;
    logic [slc_pkg::TOTAL_W-1:0]       hit_total_reg;
    logic [slc_pkg::TOTAL_W-1:0]       miss_total_reg;
    logic [slc_pkg::TOTAL_W-1:0]       evict_total_reg;

    logic [slc_pkg::SET_BITS_W-1:0]    sb_eff;
    logic [WC_W-1:0]                   ways_eff;
    logic [slc_pkg::ADDRESS_W-1:0]     addr_shifted;
    logic [SET_AW-1:0]                 set_mask;
    logic [SET_AW-1:0]                 set_calc;
    logic [5:0]                        tag_shift;
    logic [slc_pkg::TAG_W-1:0]         tag_calc;

    logic                              st_run;
    logic                              out_free;
    logic                              advance;
    logic                              in_fire;
    logic                              upd_write;
    logic                              ram_wr_en;
    logic [SET_AW-1:0]                 ram_wr_addr;
    logic [ROW_W-1:0]                  ram_wr_data;
    logic [ROW_W-1:0]                  ram_rd_data;
    logic [ROW_W-1:0]                  row_cur;
    logic [ROW_W-1:0]                  row_new;
    slc_pkg::slc_result_t              upd_res;

    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            sb_eff = slc_pkg::SET_BITS_W'(MAX_SET_BITS);
        end
        else
        begin
            sb_eff = set_bits_reg;
        end

        if (ways_in_use_reg == '0)
        begin
            ways_eff = WC_W'(1);
        end
        else if (int'(ways_in_use_reg) > MAX_WAYS)
        begin
            ways_eff = WC_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WC_W'(ways_in_use_reg);
        end

        addr_shifted = access.address >> block_bits_reg;
        for (int i = 0; i < SET_AW; i++)
        begin
            set_mask[i] = (i < int'(sb_eff));
        end
        set_calc  = addr_shifted[SET_AW-1:0] & set_mask;
        tag_shift = 6'(sb_eff) + 6'(block_bits_reg);
        tag_calc  = (tag_shift >= 6'd32) ? '0 : (access.address >> tag_shift[4:0]);
    end

    assign st_run    = (state_reg == ST_RUN);
    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = busy_reg && out_free;
    assign in_fire   = access.valid && access.ready;
    assign upd_write = advance && (op_reg != slc_pkg::OP_NONE);

    assign access.ready = st_run && (!busy_reg || out_free);

    assign row_cur = (fwd_valid_reg && (fwd_set_reg == set_reg)) ? fwd_row_reg : ram_rd_data;

    assign ram_wr_en   = !st_run || upd_write;
    assign ram_wr_addr = st_run ? set_reg : clr_cnt_reg;
    assign ram_wr_data = st_run ? row_new : '0;

    slc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_fire),
        .rd_addr (set_calc),
        .rd_data (ram_rd_data)
    );

    slc_set_update #(
        .MAX_WAYS (MAX_WAYS)
    ) u_set_update (
        .row_in   (row_cur),
        .tag      (tag_reg),
        .ways_eff (ways_eff),
        .opcode   (op_reg),
        .row_out  (row_new),
        .res      (upd_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_AW'(SETS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            set_bits_reg    <= slc_pkg::SET_BITS_RST;
            block_bits_reg  <= slc_pkg::BLOCK_BITS_RST;
            ways_in_use_reg <= slc_pkg::WAYS_IN_USE_RST;
            busy_reg        <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    slc_pkg::CFG_SET_BITS:
                    begin
                        set_bits_reg <= cfg_data[slc_pkg::SET_BITS_W-1:0];
                    end
                    slc_pkg::CFG_BLOCK_BITS:
                    begin
                        block_bits_reg <= cfg_data[slc_pkg::BLOCK_BITS_W-1:0];
                    end
                    slc_pkg::CFG_WAYS_IN_USE:
                    begin
                        ways_in_use_reg <= cfg_data[slc_pkg::WAYS_CFG_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (advance)
            begin
                busy_reg <= 1'b0;
            end

            if (upd_write)
            begin
                fwd_valid_reg <= 1'b1;
            end

            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                hit_total_reg   <= hit_total_reg + slc_pkg::TOTAL_W'(upd_res.hit_count);
                miss_total_reg  <= miss_total_reg + slc_pkg::TOTAL_W'(upd_res.missed);
                evict_total_reg <= evict_total_reg + slc_pkg::TOTAL_W'(upd_res.evicted);
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= access.opcode;
            set_reg <= set_calc;
            tag_reg <= tag_calc;
        end
        if (upd_write)
        begin
            fwd_set_reg <= set_reg;
            fwd_row_reg <= row_new;
        end
        if (advance)
        begin
            res_reg <= upd_res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.hit_count       = res_reg.hit_count;
    assign result.missed          = res_reg.missed;
    assign result.evicted         = res_reg.evicted;
    assign result.total_hits      = hit_total_reg;
    assign result.total_misses    = miss_total_reg;
    assign result.total_evictions = evict_total_reg;

    // An access that makes a lookup and does not miss must report at least one hit.
    a_lookup_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg != slc_pkg::OP_NONE) && !upd_res.missed)
        |-> (upd_res.hit_count != '0))
        else $error("lookup neither hit nor missed");

    // An eviction only happens on a miss.
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.evicted && !result.missed))
        else $error("eviction reported without a miss");

    // No new access enters while the lookup stage is blocked by a stalled result.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_free) |-> !access.ready)
        else $error("access accepted over a blocked lookup");

    // The miss total steps by exactly the miss flag of each new result.
    a_miss_total: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (miss_total_reg == $past(miss_total_reg) + slc_pkg::TOTAL_W'(res_reg.missed)))
        else $error("miss total out of step with results");

endmodule

// ===== test/lru_outcome_checker.sv =====
// Watches the cache tracker's channels, predicts every result word and compares it.
module lru_outcome_checker #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS     = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [slc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data,
    slc_access_if                           access,
    slc_result_if                           result,
    output int                              failures,
    output int                              outstanding,
    output int                              words_checked,
    output logic [slc_pkg::TOTAL_W-1:0]     hit_sum,
    output logic [slc_pkg::TOTAL_W-1:0]     miss_sum,
    output logic [slc_pkg::TOTAL_W-1:0]     evict_sum
);
    timeunit 1ns;
    timeprecision 1ps;
    import slc_pkg::*;

    localparam int LINES = (1 << MAX_SET_BITS) * MAX_WAYS;

    typedef struct packed {
        slc_result_t        flags;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
        logic [TOTAL_W-1:0] total_evictions;
    } access_outcome_t;

    logic                    line_valid [LINES];
    logic [TAG_W-1:0]        line_tag   [LINES];
    logic [AGE_W-1:0]        line_age   [LINES];
    logic [SET_BITS_W-1:0]   set_bits_q;
    logic [BLOCK_BITS_W-1:0] block_bits_q;
    logic [WAYS_CFG_W-1:0]   ways_q;
    access_outcome_t         expected_outcomes [$];

    function automatic void make_mru(int base, int way, int ways);
        logic [AGE_W-1:0] old_age;
        int i;
        old_age = line_age[base + way];
        for (i = 0; i < ways; i++)
        begin
            if (i != way && line_valid[base + i] && line_age[base + i] > old_age)
                line_age[base + i] = line_age[base + i] - 1'b1;
        end
        line_age[base + way] = AGE_W'(ways - 1);
    endfunction

    function automatic bit lookup_line(int base, logic [TAG_W-1:0] tag, int ways,
                                       output bit replaced);
        int i;
        int victim;
        replaced = 1'b0;
        for (i = 0; i < ways; i++)
        begin
            if (line_valid[base + i] && line_tag[base + i] == tag)
            begin
                make_mru(base, i, ways);
                return 1'b1;
            end
        end
        victim = -1;
        for (i = 0; i < ways && victim < 0; i++)
        begin
            if (!line_valid[base + i])
                victim = i;
        end
        if (victim < 0)
        begin
            victim = 0;
            for (i = 1; i < ways; i++)
            begin
                if (line_age[base + i] < line_age[base + victim])
                    victim = i;
            end
            replaced = 1'b1;
        end
        line_tag[base + victim]   = tag;
        line_valid[base + victim] = 1'b1;
        make_mru(base, victim, ways);
        return 1'b0;
    endfunction

    function automatic access_outcome_t predict_access(logic [OPCODE_W-1:0]  op,
                                                       logic [ADDRESS_W-1:0] addr);
        access_outcome_t  outcome;
        int               sb;
        int               ways;
        int               shift;
        int               base;
        logic [63:0]      wide;
        logic [TAG_W-1:0] tag;
        bit               replaced;
        bit               replaced_again;
        outcome = '0;
        if (op != OP_NONE)
        begin
            sb    = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_q);
            ways  = (ways_q == 0) ? 1 : (ways_q > MAX_WAYS) ? MAX_WAYS : int'(ways_q);
            shift = sb + int'(block_bits_q);
            wide  = 64'(addr);
            base  = int'((wide >> block_bits_q) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
            tag   = (shift >= 32) ? '0 : TAG_W'(wide >> shift);
            if (lookup_line(base, tag, ways, replaced))
                outcome.flags.hit_count = 2'd1;
            else
            begin
                outcome.flags.missed  = 1'b1;
                outcome.flags.evicted = replaced;
            end
            if (op == OP_MODIFY)
            begin
                if (lookup_line(base, tag, ways, replaced_again))
                    outcome.flags.hit_count = outcome.flags.hit_count + 1'b1;
            end
            hit_sum   = hit_sum + outcome.flags.hit_count;
            miss_sum  = miss_sum + outcome.flags.missed;
            evict_sum = evict_sum + outcome.flags.evicted;
        end
        outcome.total_hits      = hit_sum;
        outcome.total_misses    = miss_sum;
        outcome.total_evictions = evict_sum;
        return outcome;
    endfunction

    function automatic void check_field(string name, logic [TOTAL_W-1:0] want,
                                        logic [TOTAL_W-1:0] got);
        if (got !== want)
        begin
            failures++;
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_outcome_t want;
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < LINES; i++)
            begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_age[i]   = '0;
            end
            set_bits_q   = SET_BITS_RST;
            block_bits_q = BLOCK_BITS_RST;
            ways_q       = WAYS_IN_USE_RST;
            hit_sum      = '0;
            miss_sum     = '0;
            evict_sum    = '0;
            failures      = 0;
            words_checked = 0;
            expected_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result.valid === 1'b1 && result.ready === 1'b1)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    failures++;
                    $display("[%0t] unexpected result word: expected none, got hits %0d total %0d",
                             $time, result.hit_count, result.total_hits);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    words_checked++;
                    check_field("hit_count", want.flags.hit_count, result.hit_count);
                    check_field("missed", want.flags.missed, result.missed);
                    check_field("evicted", want.flags.evicted, result.evicted);
                    check_field("total_hits", want.total_hits, result.total_hits);
                    check_field("total_misses", want.total_misses, result.total_misses);
                    check_field("total_evictions", want.total_evictions,
                                result.total_evictions);
                end
            end
            if (access.valid === 1'b1 && access.ready === 1'b1)
                expected_outcomes.push_back(predict_access(access.opcode, access.address));
            if (cfg_wr_en === 1'b1)
            begin
                case (cfg_index)
                    CFG_SET_BITS:    set_bits_q   = cfg_data[SET_BITS_W-1:0];
                    CFG_BLOCK_BITS:  block_bits_q = cfg_data[BLOCK_BITS_W-1:0];
                    CFG_WAYS_IN_USE: ways_q       = cfg_data[WAYS_CFG_W-1:0];
                    default:         ;
                endcase
            end
            outstanding <= expected_outcomes.size();
        end
    end

endmodule

// ===== test/set_assoc_lru_cache_tracker_core_tb.sv =====
// Stimulus and verdict for the set-associative LRU cache tracker.
module set_assoc_lru_cache_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import slc_pkg::*;

    localparam int MAX_SET_BITS   = 10;
    localparam int MAX_WAYS       = 8;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 92;
    localparam int CALM_PHASE     = 3;
    localparam int HOLD_OFF_START = 10;
    localparam int HOLD_OFF_LEN   = 80;
    localparam int QUIET_LIMIT    = 3000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SET_BITS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int               failures;
    int               outstanding;
    int               words_checked;
    logic [TOTAL_W-1:0] hit_sum;
    logic [TOTAL_W-1:0] miss_sum;
    logic [TOTAL_W-1:0] evict_sum;

    int          sent_count   = 0;
    int          directed_count;
    int          geometries   = 0;
    int          eff_sb;
    int          eff_bb;
    int          eff_ways;
    logic [31:0] tag_seed;
    bit          idling       = 1'b1;
    bit          hold_off_req = 1'b0;
    int          quiet_cycles = 0;

    int phase_sb   [NUM_PHASES] = '{4, 10, 0, 3, 15, 2, 1, 6, 10};
    int phase_bb   [NUM_PHASES] = '{4, 22, 0, 5, 2, 6, 0, 12, 0};
    int phase_ways [NUM_PHASES] = '{1, 8, 8, 4, 15, 0, 3, 5, 2};

    slc_access_if access_ch ();
    slc_result_if result_ch ();

    set_assoc_lru_cache_tracker_core #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .access(access_ch),
        .result(result_ch)
    );

    lru_outcome_checker #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .access(access_ch),
        .result(result_ch),
        .failures(failures),
        .outstanding(outstanding),
        .words_checked(words_checked),
        .hit_sum(hit_sum),
        .miss_sum(miss_sum),
        .evict_sum(evict_sum)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if ((access_ch.valid === 1'b1 && access_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        bit held_off;
        held_off = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !held_off)
            begin
                result_ch.ready <= 1'b0;
                held_off = 1'b1;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            else
                result_ch.ready <= !(idling && $urandom_range(99) < 31);
        end
    end

    task automatic set_geometry(input int sb, input int bb, input int ways);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SET_BITS;
        cfg_data  <= CFG_DATA_W'(sb);
        @(posedge clk);
        cfg_index <= CFG_BLOCK_BITS;
        cfg_data  <= CFG_DATA_W'(bb);
        @(posedge clk);
        cfg_index <= CFG_WAYS_IN_USE;
        cfg_data  <= CFG_DATA_W'(ways);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        eff_sb   = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
        eff_bb   = bb;
        eff_ways = (ways == 0) ? 1 : (ways > MAX_WAYS) ? MAX_WAYS : ways;
        geometries++;
    endtask

    task automatic send_access(input logic [OPCODE_W-1:0] op, input logic [ADDRESS_W-1:0] addr);
        while (idling && $urandom_range(99) < 31)
        begin
            access_ch.valid <= 1'b0;
            @(posedge clk);
        end
        access_ch.valid   <= 1'b1;
        access_ch.opcode  <= op;
        access_ch.address <= addr;
        do
            @(posedge clk);
        while (access_ch.ready !== 1'b1);
        sent_count++;
    endtask

    task automatic drain();
        access_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [OPCODE_W-1:0] pick_opcode();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return OP_LOAD;
        if (r < 65)
            return OP_STORE;
        if (r < 95)
            return OP_MODIFY;
        return OP_NONE;
    endfunction

    // A few more tags than ways over a handful of sets keeps hits and evictions frequent.
    function automatic logic [ADDRESS_W-1:0] pick_address();
        logic [63:0] tag_part;
        logic [63:0] set_part;
        logic [63:0] offset;
        if ($urandom_range(9) == 0)
            return $urandom();
        tag_part = 64'(tag_seed ^ 32'($urandom_range(eff_ways + 1)));
        set_part = 64'($urandom_range(3)) & ((64'd1 << eff_sb) - 64'd1);
        offset   = 64'($urandom()) & ((64'd1 << eff_bb) - 64'd1);
        return ADDRESS_W'((tag_part << (eff_sb + eff_bb)) | (set_part << eff_bb) | offset);
    endfunction

    initial
    begin
        access_ch.valid   <= 1'b0;
        access_ch.opcode  <= OP_LOAD;
        access_ch.address <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_geometry(1, 4, 2);
        send_access(OP_LOAD, 32'h0000_0100);
        send_access(OP_LOAD, 32'h0000_0100);
        send_access(OP_STORE, 32'h0000_0200);
        send_access(OP_LOAD, 32'h0000_0100);
        send_access(OP_LOAD, 32'h0000_0300);
        send_access(OP_MODIFY, 32'h0000_0200);
        send_access(OP_MODIFY, 32'h0000_0300);
        send_access(OP_NONE, 32'h0000_0100);
        send_access(OP_STORE, 32'hFFFF_FFFF);
        send_access(OP_LOAD, 32'h0000_0000);
        send_access(OP_LOAD, 32'h8000_0000);
        send_access(OP_MODIFY, 32'h7FFF_FFFF);
        send_access(OP_LOAD, 32'hFFFF_FFEF);
        drain();
        set_geometry(0, 0, 1);
        send_access(OP_LOAD, 32'h0000_0040);
        send_access(OP_LOAD, 32'h0000_0080);
        drain();
        // Shrinking and regrowing the way count keeps a line in the hidden way, which hits again after regrowth.
        set_geometry(0, 0, 2);
        send_access(OP_LOAD, 32'h0000_0040);
        send_access(OP_LOAD, 32'h0000_0080);
        drain();
        set_geometry(0, 0, 1);
        send_access(OP_STORE, 32'h0000_0080);
        drain();
        set_geometry(0, 0, 2);
        send_access(OP_LOAD, 32'h0000_0080);
        send_access(OP_MODIFY, 32'h0000_0040);
        drain();
        directed_count = sent_count;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idling <= (p != CALM_PHASE);
            set_geometry(phase_sb[p], phase_bb[p], phase_ways[p]);
            tag_seed = $urandom();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == CALM_PHASE && n == HOLD_OFF_START)
                    hold_off_req <= 1'b1;
                send_access(pick_opcode(), pick_address());
            end
            drain();
        end

        repeat (4) @(posedge clk);
        $display("Sent %0d accesses (%0d directed) under %0d geometries, one long result stall.",
                 sent_count, directed_count, geometries);
        $display("Checked %0d result words: %0d hits, %0d misses, %0d evictions predicted.",
                 words_checked, hit_sum, miss_sum, evict_sum);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
